### rtl/core/bct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bct_pkg;
  localparam int unsigned CoordW = 32;
  localparam int unsigned InflW  = 16;
  localparam logic [InflW-1:0] InflOne = 16'd256;
  localparam logic signed [CoordW-1:0] CoordMax = 32'sh7FFF_FFFF;
  localparam logic signed [CoordW-1:0] CoordMin = 32'sh8000_0000;
  localparam logic KindInsert = 1'b0;
  localparam logic KindTest   = 1'b1;

  typedef struct packed {
    logic                     kind;
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] point_z;
  } in_item_t;

  typedef struct packed {
    logic                     inside_res;
    logic                     box_changed;
    logic signed [CoordW-1:0] base_x;
    logic signed [CoordW-1:0] base_y;
    logic signed [CoordW-1:0] base_z;
    logic [CoordW-1:0]        height;
    logic [CoordW-1:0]        radius;
  } out_item_t;
endpackage
`default_nettype wire

### rtl/core/bct_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface bct_in_if;
  logic               valid;
  logic               ready;
  bct_pkg::in_item_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface bct_out_if;
  logic               valid;
  logic               ready;
  bct_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

### rtl/core/bct_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// Bit-pair restoring square root, one result bit per cycle.
module bct_sqrt (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] value_i,
  output logic             done_o,
  output logic [31:0]      root_o
);
  import bct_pkg::*;
  logic [31:0] rem_q, rem_d;
  logic [63:0] dat_q, dat_d;
  logic [31:0] res_q, res_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [33:0] trial;
  logic [33:0] top;
  logic [33:0] diff;

  always_comb begin
    rem_d  = rem_q;
    dat_d  = dat_q;
    res_d  = res_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    // The partial remainder takes in the next two bits of the operand each step.
    top    = {rem_q, dat_q[63:62]};
    trial  = {res_q, 2'b01};
    diff   = top - trial;
    if (start_i) begin
      rem_d  = '0;
      dat_d  = value_i;
      res_d  = '0;
      cnt_d  = 6'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      dat_d = {dat_q[61:0], 2'b00};
      if (top >= trial) begin
        rem_d = diff[31:0];
        res_d = {res_q[30:0], 1'b1};
      end else begin
        rem_d = top[31:0];
        res_d = {res_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dat_q <= dat_d;
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign root_o = res_q;
endmodule
`default_nettype wire

### rtl/core/bounding_cylinder_tracker.sv
`timescale 1ns / 1ps
`default_nettype none
// Bounding cylinder tracker. Insert items widen an axis-aligned box around
// Q16.16 points; when a bound moves, the y range is inflated by the
// inflation_factor register (Q8.8, raised to 1.0 if lower) times the height
// and a vertical cylinder is rebuilt from the box. Test items report whether
// a point lies inside it. Each item yields one result item with the current
// cylinder. Multiplications run through one shared 33x33 multiplier under a
// small sequencer, and the radius comes from a bit-serial square root of 32
// steps. An insert that moves the box goes through StAdj, StInfl, StMid,
// StSqX, StSqZ and StRoot, then waits in StOut for the root; a test with
// a box goes through StTx, StTz and StTcmp; other items go straight to
// StOut. The input is not ready while an item is at work or its result
// is pending, and it becomes ready again in the cycle after it is taken.
module bounding_cylinder_tracker (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [bct_pkg::InflW-1:0] cfg_wdata_i,
  bct_in_if.sink                         in_if,
  bct_out_if.source                      out_if
);
  import bct_pkg::*;

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StAdj   = 4'd1;
  localparam logic [3:0] StInfl  = 4'd2;
  localparam logic [3:0] StMid   = 4'd3;
  localparam logic [3:0] StSqX   = 4'd4;
  localparam logic [3:0] StSqZ   = 4'd5;
  localparam logic [3:0] StRoot  = 4'd6;
  localparam logic [3:0] StTx    = 4'd7;
  localparam logic [3:0] StTz    = 4'd8;
  localparam logic [3:0] StTcmp  = 4'd9;
  localparam logic [3:0] StOut   = 4'd10;

  logic [3:0] state_q, state_d;
  logic [InflW-1:0] infl_q;
  logic empty_q, empty_d;
  logic signed [CoordW-1:0] mn_q [3], mn_d [3], mx_q [3], mx_d [3];
  logic signed [CoordW-1:0] bc_q [3], bc_d [3];
  logic [CoordW-1:0] hgt_q, hgt_d, rad_q;
  logic [63:0] r2_q, r2_d, acc_q, acc_d;
  in_item_t item_q, item_d;
  logic chg_q, chg_d, ins_q, ins_d;
  logic [32:0] ma, mb;
  logic [65:0] prod;
  logic [63:0] ovf_sum;
  logic sq_start, sq_done;
  logic [31:0] sq_root;
  logic signed [33:0] hraw, dif, ylo, yhi;
  logic signed [34:0] dy;
  logic [64:0] sum65;

  function automatic logic signed [CoordW-1:0] sat(input logic signed [33:0] v);
    if (v > 34'sh0_7FFF_FFFF) return CoordMax;
    if (v < -34'sh0_8000_0000) return CoordMin;
    return v[31:0];
  endfunction

  function automatic logic [32:0] absd(input logic signed [CoordW-1:0] a,
                                       input logic signed [CoordW-1:0] b);
    logic signed [33:0] d;
    d = 34'(a) - 34'(b);
    return d[33] ? 33'(-d) : d[32:0];
  endfunction

  bct_sqrt u_sqrt (
    .clk_i, .rst_ni, .start_i(sq_start), .value_i(r2_q),
    .done_o(sq_done), .root_o(sq_root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) infl_q <= InflOne;
    else if (cfg_we_i) infl_q <= (cfg_wdata_i < InflOne) ? InflOne : cfg_wdata_i;
  end

  assign prod = 66'(ma) * 66'(mb);
  assign hraw = 34'(mx_q[1]) - 34'(mn_q[1]);

  always_comb begin
    state_d = state_q; empty_d = empty_q;
    mn_d = mn_q; mx_d = mx_q; bc_d = bc_q;
    hgt_d = hgt_q; r2_d = r2_q; acc_d = acc_q;
    item_d = item_q; chg_d = chg_q; ins_d = ins_q;
    ma = '0; mb = '0; sq_start = 1'b0;
    ylo = '0; yhi = '0; dif = '0; dy = '0; sum65 = '0; ovf_sum = '0;
    unique case (state_q)
      StIdle: begin
        if (in_if.valid) begin
          item_d = in_if.payload;
          chg_d = 1'b0; ins_d = 1'b0;
          if (in_if.payload.kind == KindInsert) begin
            if (in_if.payload.point_x < mn_q[0]) begin mn_d[0] = in_if.payload.point_x; chg_d = 1'b1; end
            if (in_if.payload.point_x > mx_q[0]) begin mx_d[0] = in_if.payload.point_x; chg_d = 1'b1; end
            if (in_if.payload.point_y < mn_q[1]) begin mn_d[1] = in_if.payload.point_y; chg_d = 1'b1; end
            if (in_if.payload.point_y > mx_q[1]) begin mx_d[1] = in_if.payload.point_y; chg_d = 1'b1; end
            if (in_if.payload.point_z < mn_q[2]) begin mn_d[2] = in_if.payload.point_z; chg_d = 1'b1; end
            if (in_if.payload.point_z > mx_q[2]) begin mx_d[2] = in_if.payload.point_z; chg_d = 1'b1; end
            state_d = (chg_d) ? StAdj : StOut;
            if (chg_d) empty_d = 1'b0;
          end else begin
            state_d = empty_q ? StOut : StTx;
          end
        end
      end
      StAdj: begin
        // Inflation amount: factor times clamped height, Q8.8 scaled down.
        ma = {17'd0, infl_q};
        mb = hraw[33] ? 33'd0 : hraw[32:0];
        acc_d = 64'(prod >> 8);
        state_d = StInfl;
      end
      StInfl: begin
        // Any amount of 2^32 or more saturates both bounds, so it is clamped there.
        ylo = 34'(mn_q[1]) - (acc_q[63:32] != 0 ? 34'sh1_0000_0000 : $signed({2'b00, acc_q[31:0]}));
        yhi = 34'(mx_q[1]) + (acc_q[63:32] != 0 ? 34'sh1_0000_0000 : $signed({2'b00, acc_q[31:0]}));
        mn_d[1] = sat(ylo);
        mx_d[1] = sat(yhi);
        state_d = StMid;
      end
      StMid: begin
        dif = 34'(mx_q[1]) - 34'(mn_q[1]);
        hgt_d = dif[33] ? '0 : dif[31:0];
        bc_d[1] = mn_q[1];
        sum65 = 65'(35'(mn_q[0]) + 35'(mx_q[0]));
        bc_d[0] = sum65[32:1];
        sum65 = 65'(35'(mn_q[2]) + 35'(mx_q[2]));
        bc_d[2] = sum65[32:1];
        state_d = StSqX;
      end
      StSqX: begin
        ma = absd(mn_q[0], bc_q[0]); mb = ma;
        acc_d = prod[63:0];
        state_d = StSqZ;
      end
      StSqZ: begin
        ma = absd(mn_q[2], bc_q[2]); mb = ma;
        r2_d = acc_q + prod[63:0];
        state_d = StRoot;
      end
      StRoot: begin
        sq_start = 1'b1;
        state_d = StOut;
      end
      StTx: begin
        ma = absd(item_q.point_x, bc_q[0]); mb = ma;
        acc_d = prod[63:0];
        state_d = StTz;
      end
      StTz: begin
        ma = absd(item_q.point_z, bc_q[2]); mb = ma;
        sum65 = 65'(acc_q) + 65'(prod[63:0]);
        acc_d = sum65[64] ? '1 : sum65[63:0];
        state_d = StTcmp;
      end
      StTcmp: begin
        dy = 35'(item_q.point_y) - 35'(bc_q[1]);
        ovf_sum = acc_q;
        ins_d = (ovf_sum <= r2_q) && (dy > 0) && (dy < 35'($signed({3'b0, hgt_q})));
        state_d = StOut;
      end
      StOut: begin
        if (out_if.ready && out_if.valid) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // Radius register tracks the square root; it is held between inserts.
  logic root_busy_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; empty_q <= 1'b1;
      for (int i = 0; i < 3; i++) begin
        mn_q[i] <= CoordMax; mx_q[i] <= CoordMin; bc_q[i] <= '0;
      end
      hgt_q <= '0; r2_q <= '0; rad_q <= '0; root_busy_q <= 1'b0;
      chg_q <= 1'b0; ins_q <= 1'b0;
    end else begin
      state_q <= state_d; empty_q <= empty_d;
      mn_q <= mn_d; mx_q <= mx_d; bc_q <= bc_d;
      hgt_q <= hgt_d; r2_q <= r2_d;
      chg_q <= chg_d; ins_q <= ins_d;
      if (sq_start) root_busy_q <= 1'b1;
      else if (sq_done) begin root_busy_q <= 1'b0; rad_q <= sq_root; end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    item_q <= item_d;
  end

  assign in_if.ready = (state_q == StIdle);
  assign out_if.valid = (state_q == StOut) && !root_busy_q && !sq_start;
  assign out_if.payload.inside_res  = ins_q;
  assign out_if.payload.box_changed = chg_q;
  assign out_if.payload.base_x = bc_q[0];
  assign out_if.payload.base_y = bc_q[1];
  assign out_if.payload.base_z = bc_q[2];
  assign out_if.payload.height = hgt_q;
  assign out_if.payload.radius = rad_q;
endmodule
`default_nettype wire

### rtl/core/bct_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module bct_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_i,
  input wire logic out_valid_i,
  input wire logic out_ready_i,
  input wire logic out_inside_i,
  input wire logic out_changed_i
);
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i) else $error("input ready while result pending");
  a_accept_then_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i) else $error("ready after accept");
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(out_inside_i && out_changed_i)) else $error("both flags set");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i) else $error("result dropped");
endmodule

bind bounding_cylinder_tracker bct_checker u_bct_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid_i(in_if.valid), .in_ready_i(in_if.ready),
  .out_valid_i(out_if.valid), .out_ready_i(out_if.ready),
  .out_inside_i(out_if.payload.inside_res), .out_changed_i(out_if.payload.box_changed)
);
`default_nettype wire
